// ===== hdl/crgb_pkg.sv =====
// Shared types, codes and color stop tables for the scalar-to-RGB color ramp.
// No dependencies; imported by the root cell, the mixer, the top level and the testbench files.
package crgb_pkg;

  // Ramp selection held in the configuration register
  typedef enum logic {
    MODE_RAINBOW = 1'b0,
    MODE_SQRT    = 1'b1
  } ramp_mode_t;

  // Stop component in tenths of full scale (0..10)
  typedef logic [3:0] tenth_t;

  typedef struct packed {
    tenth_t red;
    tenth_t green;
    tenth_t blue;
  } stop_t;

  typedef logic [2:0] seg_t;

  // Index of the last stop of each ramp (stop count minus one)
  localparam seg_t RAINBOW_LAST = 3'd6;
  localparam seg_t SQRT_LAST    = 3'd5;

  // Color stop lookup for both ramps
  function automatic stop_t ramp_stop(input ramp_mode_t mode, input seg_t idx);
    stop_t s;
    s = '0;
    if (mode == MODE_RAINBOW) begin
      case (idx)
        3'd0:    s = '{4'd10, 4'd0,  4'd0};
        3'd1:    s = '{4'd10, 4'd5,  4'd0};
        3'd2:    s = '{4'd10, 4'd10, 4'd0};
        3'd3:    s = '{4'd0,  4'd10, 4'd0};
        3'd4:    s = '{4'd0,  4'd10, 4'd10};
        3'd5:    s = '{4'd0,  4'd0,  4'd10};
        3'd6:    s = '{4'd10, 4'd0,  4'd10};
        default: s = '0;
      endcase
    end else begin
      case (idx)
        3'd0:    s = '{4'd0,  4'd2,  4'd10};
        3'd1:    s = '{4'd0,  4'd10, 4'd10};
        3'd2:    s = '{4'd0,  4'd10, 4'd0};
        3'd3:    s = '{4'd10, 4'd10, 4'd0};
        3'd4:    s = '{4'd10, 4'd5,  4'd0};
        3'd5:    s = '{4'd10, 4'd0,  4'd0};
        default: s = '0;
      endcase
    end
    return s;
  endfunction

endpackage

// ===== hdl/crgb_sqrt_cell.sv =====
// One cell of the square-root chain: resolves one root bit per beat.
// Depends on crgb_pkg (house import only); instanced in a row by the top level.
module crgb_sqrt_cell #(
  parameter int ROOT_BITS = 17
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  logic [2*ROOT_BITS-1:0] up_rad,
  input  logic [ROOT_BITS:0]     up_rem,
  input  logic [ROOT_BITS-1:0]   up_root,
  input  logic [ROOT_BITS-1:0]   up_level,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output logic [2*ROOT_BITS-1:0] dn_rad,
  output logic [ROOT_BITS:0]     dn_rem,
  output logic [ROOT_BITS-1:0]   dn_root,
  output logic [ROOT_BITS-1:0]   dn_level
);
  import crgb_pkg::*;

  logic                   vld_r;
  logic [2*ROOT_BITS-1:0] rad_r;
  logic [ROOT_BITS:0]     rem_r, rem_nxt;
  logic [ROOT_BITS-1:0]   root_r, root_nxt;
  logic [ROOT_BITS-1:0]   level_r;
  logic [ROOT_BITS+2:0]   cur;
  logic [ROOT_BITS+2:0]   trial;
  logic                   take;

  // Bring down the next two radicand bits and try the next root bit
  assign cur   = {up_rem, up_rad[2*ROOT_BITS-1 -: 2]};
  assign trial = {1'b0, up_root, 2'b01};
  assign take  = (cur >= trial);

  always_comb begin
    if (take) begin
      rem_nxt = (ROOT_BITS+1)'(cur - trial);
    end else begin
      rem_nxt = cur[ROOT_BITS:0];
    end
    root_nxt = {up_root[ROOT_BITS-2:0], take};
  end

  // Slot is free when empty or when the neighbor takes the held beat
  assign up_ready = !vld_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (up_ready) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      rad_r   <= {up_rad[2*ROOT_BITS-3:0], 2'b00};
      rem_r   <= rem_nxt;
      root_r  <= root_nxt;
      level_r <= up_level;
    end
  end

  assign dn_valid = vld_r;
  assign dn_rad   = rad_r;
  assign dn_rem   = rem_r;
  assign dn_root  = root_r;
  assign dn_level = level_r;

endmodule

// ===== hdl/crgb_mix.sv =====
// Ramp position, stop interpolation and rounding to channel width: three stages.
// Depends on crgb_pkg for the stop tables and ramp mode codes.
module crgb_mix #(
  parameter int LEVEL_FRAC_BITS = 16,
  parameter int CHANNEL_BITS    = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  crgb_pkg::ramp_mode_t     up_mode,
  input  logic [LEVEL_FRAC_BITS:0] up_level,
  input  logic [LEVEL_FRAC_BITS:0] up_root,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output logic [CHANNEL_BITS-1:0]  dn_red,
  output logic [CHANNEL_BITS-1:0]  dn_green,
  output logic [CHANNEL_BITS-1:0]  dn_blue
);
  import crgb_pkg::*;

  localparam int LB         = LEVEL_FRAC_BITS + 1;
  localparam int POS_BITS   = LB + 3;
  localparam int W_BITS     = LB + 3;
  localparam int SC_BITS    = W_BITS + CHANNEL_BITS;
  localparam int T_BITS     = CHANNEL_BITS + 4;
  localparam int DIV_SHIFT  = T_BITS + 4;
  localparam int PROD_BITS  = 2 * T_BITS + 1;
  localparam longint RECIP_L = ((64'sd1 <<< DIV_SHIFT) + 64'sd9) / 64'sd10;
  localparam logic [T_BITS:0]  RECIP    = RECIP_L[T_BITS:0];
  localparam logic [LB-1:0]    LVL_ONE  = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
  localparam logic [SC_BITS-1:0] RND_HALF = SC_BITS'(5) << LEVEL_FRAC_BITS;

  // ---------------- stage A: segment and fraction ----------------
  logic            a_vld_r, a_rdy;
  seg_t            a_seg_r, a_seg_nxt;
  logic [LB-1:0]   a_frac_r, a_frac_nxt;
  ramp_mode_t      a_mode_r;
  logic            a_black_r, a_black_nxt;
  logic [LB-1:0]   x;
  seg_t            last;
  logic [POS_BITS-1:0] pos;
  logic [3:0]      seg_raw;

  // ---------------- stage B: interpolated, rounded channel ----------------
  logic              b_vld_r, b_rdy;
  logic [T_BITS-1:0] b_t_r   [3];
  logic [T_BITS-1:0] b_t_nxt [3];
  stop_t             stop_lo, stop_hi;
  tenth_t            lo [3];
  tenth_t            hi [3];
  logic [LB-1:0]     inv;
  logic [W_BITS-1:0] w   [3];
  logic [SC_BITS-1:0] sc [3];

  // ---------------- stage C: divide by ten, output register ----------------
  logic                    c_vld_r, c_rdy;
  logic [CHANNEL_BITS-1:0] c_ch_r   [3];
  logic [CHANNEL_BITS-1:0] c_ch_nxt [3];
  logic [PROD_BITS-1:0]    prod     [3];

  // Backpressure ripples back through the three stages
  assign c_rdy    = !c_vld_r || dn_ready;
  assign b_rdy    = !b_vld_r || c_rdy;
  assign a_rdy    = !a_vld_r || b_rdy;
  assign up_ready = a_rdy;

  // Locate the segment; clamp full scale onto the last segment
  always_comb begin
    x       = (up_mode == MODE_SQRT) ? up_root : up_level;
    last    = (up_mode == MODE_SQRT) ? SQRT_LAST : RAINBOW_LAST;
    pos     = POS_BITS'(x) * POS_BITS'(last);
    seg_raw = pos[LEVEL_FRAC_BITS +: 4];
    if (seg_raw >= {1'b0, last}) begin
      a_seg_nxt  = last - 3'd1;
      a_frac_nxt = LVL_ONE;
    end else begin
      a_seg_nxt  = seg_raw[2:0];
      a_frac_nxt = {1'b0, pos[LEVEL_FRAC_BITS-1:0]};
    end
    a_black_nxt = (up_mode == MODE_SQRT) && (up_level == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (a_rdy) begin
      a_vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && a_rdy) begin
      a_seg_r   <= a_seg_nxt;
      a_frac_r  <= a_frac_nxt;
      a_mode_r  <= up_mode;
      a_black_r <= a_black_nxt;
    end
  end

  // Blend the two stops, scale to channel range, add half and drop fraction
  always_comb begin
    stop_lo = ramp_stop(a_mode_r, a_seg_r);
    stop_hi = ramp_stop(a_mode_r, a_seg_r + 3'd1);
    lo[0] = stop_lo.red;
    lo[1] = stop_lo.green;
    lo[2] = stop_lo.blue;
    hi[0] = stop_hi.red;
    hi[1] = stop_hi.green;
    hi[2] = stop_hi.blue;
    inv   = LVL_ONE - a_frac_r;
    for (int c = 0; c < 3; c++) begin
      w[c]  = W_BITS'(lo[c]) * W_BITS'(inv) + W_BITS'(hi[c]) * W_BITS'(a_frac_r);
      sc[c] = (SC_BITS'(w[c]) << CHANNEL_BITS) - SC_BITS'(w[c]) + RND_HALF;
      b_t_nxt[c] = a_black_r ? '0 : sc[c][LEVEL_FRAC_BITS +: T_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (b_rdy) begin
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_vld_r && b_rdy) begin
      b_t_r <= b_t_nxt;
    end
  end

  // Divide by ten through a reciprocal multiply
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c]     = PROD_BITS'(b_t_r[c]) * PROD_BITS'(RECIP);
      c_ch_nxt[c] = prod[c][DIV_SHIFT +: CHANNEL_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (c_rdy) begin
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld_r && c_rdy) begin
      c_ch_r <= c_ch_nxt;
    end
  end

  assign dn_valid = c_vld_r;
  assign dn_red   = c_ch_r[0];
  assign dn_green = c_ch_r[1];
  assign dn_blue  = c_ch_r[2];

endmodule

// ===== hdl/scalar_to_rgb_color_ramp.sv =====
// Top level of the scalar-to-RGB color ramp: config register, root chain, mixer.
// Depends on crgb_pkg, crgb_sqrt_cell and crgb_mix.

// Colors one level sample per beat. A level in Q1.LEVEL_FRAC_BITS (values above
// 1.0 saturate to 1.0) is mapped by linear interpolation between color stops:
// ramp mode 0 is a seven-stop rainbow (red to magenta) indexed by the level,
// ramp mode 1 a six-stop ramp (blue to red) indexed by the square root of the
// level, with black for a level of zero. Channels are rounded half up. The block
// takes one beat per clock while backpressure does not reach the input. It is a
// row of LEVEL_FRAC_BITS + 1 square-root cells, one root bit each, then three
// mixing stages, the last of which is the output register. Every stage has its
// own valid bit, so bubbles collapse and the input keeps flowing while a result
// waits. Write cfg_wr_data only while no beat is in flight.
module scalar_to_rgb_color_ramp #(
  parameter int LEVEL_FRAC_BITS = 16,
  parameter int CHANNEL_BITS    = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [LEVEL_FRAC_BITS:0] in_level,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [CHANNEL_BITS-1:0]  out_red,
  output logic [CHANNEL_BITS-1:0]  out_green,
  output logic [CHANNEL_BITS-1:0]  out_blue
);
  import crgb_pkg::*;

  localparam int N = LEVEL_FRAC_BITS + 1;
  localparam logic [N-1:0] LVL_ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

  ramp_mode_t ramp_mode_r;
  logic [N-1:0] level_sat;

  logic [N:0]              vld_c;
  logic [N:0]              rdy_c;
  logic [N:0][2*N-1:0]     rad_c;
  logic [N:0][N:0]         rem_c;
  logic [N:0][N-1:0]       root_c;
  logic [N:0][N-1:0]       level_c;

  // Hold the ramp mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_mode_r <= MODE_RAINBOW;
    end else if (cfg_wr_en) begin
      ramp_mode_r <= ramp_mode_t'(cfg_wr_data);
    end
  end

  // Saturate the level at 1.0 and seed the root chain
  assign level_sat  = (in_level > LVL_ONE) ? LVL_ONE : in_level;
  assign vld_c[0]   = in_valid;
  assign in_ready   = rdy_c[0];
  assign rad_c[0]   = {1'b0, level_sat, {LEVEL_FRAC_BITS{1'b0}}};
  assign rem_c[0]   = '0;
  assign root_c[0]  = '0;
  assign level_c[0] = level_sat;

  // Square-root chain, one result bit per cell
  for (genvar i = 0; i < N; i++) begin : g_cell
    crgb_sqrt_cell #(
      .ROOT_BITS(N)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld_c[i]),
      .up_ready (rdy_c[i]),
      .up_rad   (rad_c[i]),
      .up_rem   (rem_c[i]),
      .up_root  (root_c[i]),
      .up_level (level_c[i]),
      .dn_valid (vld_c[i+1]),
      .dn_ready (rdy_c[i+1]),
      .dn_rad   (rad_c[i+1]),
      .dn_rem   (rem_c[i+1]),
      .dn_root  (root_c[i+1]),
      .dn_level (level_c[i+1])
    );
  end

  crgb_mix #(
    .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS),
    .CHANNEL_BITS   (CHANNEL_BITS)
  ) u_mix (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (vld_c[N]),
    .up_ready (rdy_c[N]),
    .up_mode  (ramp_mode_r),
    .up_level (level_c[N]),
    .up_root  (root_c[N]),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_red   (out_red),
    .dn_green (out_green),
    .dn_blue  (out_blue)
  );

endmodule

// ===== hdl/crgb_checker.sv =====
// Port-level checks for the scalar-to-RGB color ramp, bound to the top level.
// Depends on scalar_to_rgb_color_ramp ports only.
module crgb_checker #(
  parameter int LEVEL_FRAC_BITS = 16,
  parameter int CHANNEL_BITS    = 8
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [CHANNEL_BITS-1:0] out_red,
  input logic [CHANNEL_BITS-1:0] out_green,
  input logic [CHANNEL_BITS-1:0] out_blue
);

  localparam logic [7:0] DEPTH = 8'(LEVEL_FRAC_BITS + 4);

  logic [7:0] in_flight_r, in_flight_nxt;

  // Track beats accepted but not yet delivered
  always_comb begin
    in_flight_nxt = in_flight_r;
    if (in_valid && in_ready && !(out_valid && out_ready)) begin
      in_flight_nxt = in_flight_r + 8'd1;
    end else if (!(in_valid && in_ready) && out_valid && out_ready) begin
      in_flight_nxt = in_flight_r - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_flight_r <= '0;
    end else begin
      in_flight_r <= in_flight_nxt;
    end
  end

  // Stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue))
    else $error("stalled result changed");

  // An empty output stage means the whole row can take a beat
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with no result waiting");

  // Never deliver a beat that was not accepted
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_flight_r != 8'd0)
    else $error("result without accepted input");

  // Occupancy never exceeds the number of pipeline stages
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    in_flight_r <= DEPTH)
    else $error("more beats in flight than stages");

endmodule

bind scalar_to_rgb_color_ramp crgb_checker #(
  .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS),
  .CHANNEL_BITS   (CHANNEL_BITS)
) u_crgb_checker (.*);

// ===== verif/crgb_color_checker.sv =====
// Scoreboard for the scalar-to-RGB color ramp: watches the config port, the level input and the color output.
// Predicts each output color from its own stop tables and compares it per channel.
// Depends on crgb_pkg for the ramp mode type.
module crgb_color_checker #(
  parameter int LEVEL_FRAC_BITS = 16,
  parameter int CHANNEL_BITS    = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic                     cfg_wr_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [LEVEL_FRAC_BITS:0] in_level,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [CHANNEL_BITS-1:0]  out_red,
  input  logic [CHANNEL_BITS-1:0]  out_green,
  input  logic [CHANNEL_BITS-1:0]  out_blue,
  output int                       mismatch_count,
  output int                       colors_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  import crgb_pkg::*;

  localparam logic [63:0] UNITY    = 64'd1 << LEVEL_FRAC_BITS;
  localparam logic [63:0] CH_FULL  = (64'd1 << CHANNEL_BITS) - 64'd1;
  localparam int          REPORT_MAX = 10;

  typedef struct packed {
    ramp_mode_t                 mode;
    logic [LEVEL_FRAC_BITS:0]   level;
    logic [CHANNEL_BITS-1:0]    red;
    logic [CHANNEL_BITS-1:0]    green;
    logic [CHANNEL_BITS-1:0]    blue;
  } color_beat_t;

  color_beat_t color_q[$];
  ramp_mode_t  ramp_sel;
  int          bad_beats;

  // Stop colors in tenths of full scale, packed as {red, green, blue}
  function automatic logic [11:0] stop_tenths(input ramp_mode_t mode, input int idx);
    logic [11:0] t;
    t = '0;
    if (mode == MODE_RAINBOW) begin
      case (idx)
        0: t = {4'd10, 4'd0,  4'd0};
        1: t = {4'd10, 4'd5,  4'd0};
        2: t = {4'd10, 4'd10, 4'd0};
        3: t = {4'd0,  4'd10, 4'd0};
        4: t = {4'd0,  4'd10, 4'd10};
        5: t = {4'd0,  4'd0,  4'd10};
        6: t = {4'd10, 4'd0,  4'd10};
        default: t = '0;
      endcase
    end else begin
      case (idx)
        0: t = {4'd0,  4'd2,  4'd10};
        1: t = {4'd0,  4'd10, 4'd10};
        2: t = {4'd0,  4'd10, 4'd0};
        3: t = {4'd10, 4'd10, 4'd0};
        4: t = {4'd10, 4'd5,  4'd0};
        5: t = {4'd10, 4'd0,  4'd0};
        default: t = '0;
      endcase
    end
    return t;
  endfunction

  // Truncated square root, two bits of the radicand per step
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Interpolate one channel between two stops and round half up to full scale
  function automatic logic [CHANNEL_BITS-1:0] blend(input logic [3:0] a, input logic [3:0] b,
                                                    input logic [63:0] frac);
    logic [63:0] num;
    logic [63:0] den;
    num = CH_FULL * (64'(a) * (UNITY - frac) + 64'(b) * frac);
    den = 64'd10 * UNITY;
    return CHANNEL_BITS'((num + den / 2) / den);
  endfunction

  function automatic color_beat_t predict_color(input ramp_mode_t mode,
                                                input logic [LEVEL_FRAC_BITS:0] level);
    logic [63:0] lvl;
    logic [63:0] x;
    logic [63:0] pos;
    logic [63:0] frac;
    logic [11:0] lo;
    logic [11:0] hi;
    int          seg;
    int          last;
    color_beat_t c;
    c       = '0;
    c.mode  = mode;
    c.level = level;
    // Saturate anything above 1.0
    lvl = 64'(level);
    if (lvl > UNITY) lvl = UNITY;
    // Root ramp gives black at zero
    if (mode == MODE_SQRT && lvl == 0) return c;
    if (mode == MODE_RAINBOW) begin
      x    = lvl;
      last = 6;
    end else begin
      x = floor_root(lvl << LEVEL_FRAC_BITS);
      if (x > UNITY) x = UNITY;
      last = 5;
    end
    pos  = x * 64'(last);
    seg  = int'(pos >> LEVEL_FRAC_BITS);
    frac = pos & (UNITY - 64'd1);
    // Full scale lands on the last stop
    if (seg >= last) begin
      seg  = last - 1;
      frac = UNITY;
    end
    lo      = stop_tenths(mode, seg);
    hi      = stop_tenths(mode, seg + 1);
    c.red   = blend(lo[11:8], hi[11:8], frac);
    c.green = blend(lo[7:4],  hi[7:4],  frac);
    c.blue  = blend(lo[3:0],  hi[3:0],  frac);
    return c;
  endfunction

  initial begin
    ramp_sel         = MODE_RAINBOW;
    bad_beats        = 0;
    mismatch_count   = 0;
    colors_in_flight = 0;
  end

  always @(posedge clk) begin
    color_beat_t want;
    if (!rst_n) begin
      ramp_sel = MODE_RAINBOW;
      color_q.delete();
    end else begin
      // Compare each output beat with the oldest prediction
      if (out_valid && out_ready) begin
        if (color_q.size() == 0) begin
          bad_beats++;
          if (bad_beats <= REPORT_MAX)
            $display("%0t: unexpected color beat %0d/%0d/%0d", $realtime,
                     out_red, out_green, out_blue);
        end else begin
          want = color_q.pop_front();
          if (want.red !== out_red || want.green !== out_green || want.blue !== out_blue) begin
            bad_beats++;
            if (bad_beats <= REPORT_MAX)
              $display("%0t: level %0d mode %s: expected rgb %0d/%0d/%0d, got %0d/%0d/%0d",
                       $realtime, want.level, want.mode.name(), want.red, want.green,
                       want.blue, out_red, out_green, out_blue);
          end
        end
      end
      // Predict each accepted level beat
      if (in_valid && in_ready)
        color_q.push_back(predict_color(ramp_sel, in_level));
      // Track the mode register
      if (cfg_wr_en)
        ramp_sel = ramp_mode_t'(cfg_wr_data);
    end
    mismatch_count   <= bad_beats;
    colors_in_flight <= color_q.size();
  end

endmodule

// ===== verif/tb_scalar_to_rgb_color_ramp.sv =====
// Testbench top for the scalar-to-RGB color ramp: clock, reset, stimulus and verdict.
// Depends on crgb_pkg, crgb_color_checker and the scalar_to_rgb_color_ramp RTL.
module tb_scalar_to_rgb_color_ramp;
  timeunit 1ns;
  timeprecision 1ps;

  import crgb_pkg::*;

  localparam int LEVEL_FRAC_BITS = 16;
  localparam int CHANNEL_BITS    = 8;
  localparam int LATENCY         = LEVEL_FRAC_BITS + 4;
  localparam int HOLD_CYCLES     = 250;
  localparam int HOLD_AT_BEAT    = 300;
  localparam int CYCLE_LIMIT     = 200000;
  localparam logic [LEVEL_FRAC_BITS:0] FULL_LEVEL =
    (LEVEL_FRAC_BITS + 1)'(1) << LEVEL_FRAC_BITS;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_wr_en;
  logic                     cfg_wr_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [LEVEL_FRAC_BITS:0] in_level;
  logic                     out_valid;
  logic                     out_ready;
  logic [CHANNEL_BITS-1:0]  out_red;
  logic [CHANNEL_BITS-1:0]  out_green;
  logic [CHANNEL_BITS-1:0]  out_blue;
  int                       mismatch_count;
  int                       colors_in_flight;
  int                       cycle_count;
  int                       sent_beats;
  bit                       sender_calm;

  scalar_to_rgb_color_ramp #(
    .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS),
    .CHANNEL_BITS   (CHANNEL_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_level   (in_level),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue)
  );

  crgb_color_checker #(
    .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS),
    .CHANNEL_BITS   (CHANNEL_BITS)
  ) u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_level        (in_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .mismatch_count  (mismatch_count),
    .colors_in_flight(colors_in_flight)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Abort a hung run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one level beat after a random gap and hold it until accepted
  task automatic offer_level(input logic [LEVEL_FRAC_BITS:0] lvl);
    int gap;
    if (sent_beats % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
    gap = sender_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_level <= lvl;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_beats++;
  endtask

  // Drop valid and wait until every predicted color has come out
  task automatic drain_colors();
    in_valid <= 1'b0;
    @(posedge clk);
    while (colors_in_flight != 0) @(posedge clk);
  endtask

  // Write the mode register while the pipe is empty
  task automatic set_ramp_mode(input ramp_mode_t mode);
    drain_colors();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mostly in-range levels, with corners and over-range values mixed in
  function automatic logic [LEVEL_FRAC_BITS:0] pick_level();
    logic [LEVEL_FRAC_BITS:0] lvl;
    case ($urandom_range(0, 9))
      0:       lvl = (LEVEL_FRAC_BITS + 1)'($urandom_range(0, 3));
      1:       lvl = (LEVEL_FRAC_BITS + 1)'($urandom_range(FULL_LEVEL - 4, FULL_LEVEL));
      2:       lvl = (LEVEL_FRAC_BITS + 1)'($urandom());
      default: lvl = (LEVEL_FRAC_BITS + 1)'($urandom_range(0, FULL_LEVEL));
    endcase
    return lvl;
  endfunction

  task automatic run_random_levels(input int count);
    repeat (count) offer_level(pick_level());
  endtask

  // Receiver: random stalls, calm stretches, and one long hold-off
  initial begin
    int stall;
    int rx_beats;
    bit rx_calm;
    rx_beats = 0;
    rx_calm  = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_beats % 50 == 0) rx_calm = ($urandom_range(0, 3) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 6);
      if (rx_beats == HOLD_AT_BEAT) stall = HOLD_CYCLES;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      rx_beats++;
    end
  end

  // Stimulus and verdict
  initial begin
    sent_beats  = 0;
    sender_calm = 1'b0;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 1'b0;
    in_valid    <= 1'b0;
    in_level    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Rainbow ramp from reset: ends, stop boundaries, saturation
    offer_level(0);
    offer_level(1);
    offer_level(10922);
    offer_level(10923);
    offer_level(21845);
    offer_level(32768);
    offer_level(43691);
    offer_level(54613);
    offer_level(FULL_LEVEL - 1);
    offer_level(FULL_LEVEL);
    offer_level(FULL_LEVEL + 1);
    offer_level('1);

    // Root ramp: black at zero, tiny levels, stop boundaries, full scale
    set_ramp_mode(MODE_SQRT);
    offer_level(0);
    offer_level(1);
    offer_level(2);
    offer_level(2621);
    offer_level(10486);
    offer_level(23593);
    offer_level(41943);
    offer_level(FULL_LEVEL - 1);
    offer_level(FULL_LEVEL);
    offer_level(100000);
    offer_level('1);

    // Random phases, alternating the ramp
    set_ramp_mode(MODE_RAINBOW);
    run_random_levels(450);
    set_ramp_mode(MODE_SQRT);
    run_random_levels(450);
    set_ramp_mode(MODE_RAINBOW);
    run_random_levels(400);
    set_ramp_mode(MODE_SQRT);
    run_random_levels(430);

    drain_colors();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0 && colors_in_flight == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
